// ===== rtl/sgb_pkg.sv =====
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared types, register codes and pixel arithmetic for the separable blur.
// ----------------------------------------------------------------------------
package sgb_pkg;

  typedef logic [23:0] pix_t;
  typedef logic [15:0] coef_t;

  localparam int NUM_COEF   = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_KERNEL_SIZE  = 3'd2,
    REG_COEF_TAP0    = 3'd3,
    REG_COEF_TAP1    = 3'd4,
    REG_COEF_TAP2    = 3'd5,
    REG_COEF_TAP3    = 3'd6,
    REG_COEF_TAP4    = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef struct packed {
    logic shift;
    logic clear;
    logic load;
  } cell_ctrl_t;

  // Each channel times a Q0.16 weight, truncated to its integer part.
  function automatic pix_t pix_terms(pix_t p, coef_t c);
    logic [23:0] prod;
    pix_t        res;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      prod = p[8*ch +: 8] * c;
      res[8*ch +: 8] = prod[23:16];
    end
    return res;
  endfunction

endpackage

// ===== rtl/sgb_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sgb_cfg_if
// Register write channel: index and data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sgb_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [sgb_pkg::CFG_IDX_W-1:0]     index;
  logic [sgb_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sgb_in_if.sv =====
// ----------------------------------------------------------------------------
// sgb_in_if
// Input pixel channel: operation code and one RGB888 pixel per beat.
// ----------------------------------------------------------------------------
interface sgb_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] blue_in;
  logic [7:0] green_in;
  logic [7:0] red_in;

  modport source (output valid, output operation, output blue_in, output green_in,
                  output red_in, input ready);
  modport sink   (input valid, input operation, input blue_in, input green_in,
                  input red_in, output ready);
endinterface

// ===== rtl/sgb_out_if.sv =====
// ----------------------------------------------------------------------------
// sgb_out_if
// Result channel: one filtered RGB888 pixel and a frame end flag per beat.
// ----------------------------------------------------------------------------
interface sgb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue_out;
  logic [7:0] green_out;
  logic [7:0] red_out;
  logic       frame_end;

  modport source (output valid, output blue_out, output green_out, output red_out,
                  output frame_end, input ready);
  modport sink   (input valid, input blue_out, input green_out, input red_out,
                  input frame_end, output ready);
endinterface

// ===== rtl/sgb_ram.sv =====
// ----------------------------------------------------------------------------
// sgb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module sgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/sgb_cell.sv =====
// ----------------------------------------------------------------------------
// sgb_cell
// One position of the horizontal window: holds a pixel, hands it to the next
// cell on a shift and registers the weighted terms of its incoming pixel.
// ----------------------------------------------------------------------------
module sgb_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  sgb_pkg::cell_ctrl_t ctrl,
  input  sgb_pkg::pix_t       pix_in,
  input  sgb_pkg::coef_t      coef,
  output sgb_pkg::pix_t       pix_q,
  output sgb_pkg::pix_t       prod_q
);

  sgb_pkg::pix_t pix_r;
  sgb_pkg::pix_t prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      pix_r <= '0;
    end else if (ctrl.shift) begin
      pix_r <= pix_in;
    end
  end

  // The incoming pixel is what this cell holds once the shift is done.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod_r <= sgb_pkg::pix_terms(pix_in, coef);
    end
  end

  assign pix_q  = pix_r;
  assign prod_q = prod_r;

endmodule

// ===== rtl/separable_gaussian_blur_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// separable_gaussian_blur_rgb_unit
// Separable Gaussian blur (up to 5 taps) on an RGB888 raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_ch writes the geometry, kernel size and five Q0.16 weights while the
//   block is idle; a geometry or kernel size write abandons the current frame.
//   in_ch takes one beat per cycle: a data pixel or a drain tick. out_ch gives
//   the filtered pixels in raster order with frame_end on the last one.
//   Throughput is one beat per cycle while out_ch does not stall. With
//   radius r the beat that completes a result comes r*width + r beats
//   after the matching input, so drain ticks flush the tail of a frame.
//   The column pass reads earlier rows from one RAM bank per stored row, all
//   banks read in parallel at one column; the row pass is a chain of window
//   cells that shifts once per beat.
//   A stall on out_ch holds the whole pipeline; the output register keeps
//   its result and in_ch.ready drops only while that result is not taken.
//   Reset restores the default registers and clears all counters and the
//   window. The row store is not cleared: a frame only reads rows it wrote.
// ----------------------------------------------------------------------------
module separable_gaussian_blur_rgb_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096,
  parameter int MAX_TAPS   = 5
) (
  input  logic        clk,
  input  logic        rst_n,
  sgb_cfg_if.sink     cfg_ch,
  sgb_in_if.sink      in_ch,
  sgb_out_if.source   out_ch
);

  localparam int SR   = MAX_TAPS - 1;
  localparam int NT   = MAX_TAPS;
  localparam int BW   = $clog2(SR);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int RMAX = ((MAX_TAPS - 1) / 2 > 2) ? 2 : (MAX_TAPS - 1) / 2;
  localparam int SW   = 8 + $clog2(MAX_TAPS);

  // Configuration registers.
  logic [10:0]          width_r;
  logic [12:0]          height_r;
  logic [2:0]           ksize_r;
  sgb_pkg::coef_t       coef_r [sgb_pkg::NUM_COEF];
  logic                 cfg_acc;
  logic                 cfg_restart;
  sgb_pkg::cfg_reg_t    cfg_idx;

  assign cfg_ch.ready = 1'b1;
  assign cfg_acc      = cfg_ch.valid;
  assign cfg_idx      = sgb_pkg::cfg_reg_t'(cfg_ch.index);
  assign cfg_restart  = cfg_acc && (cfg_idx == sgb_pkg::REG_IMAGE_WIDTH ||
                                    cfg_idx == sgb_pkg::REG_IMAGE_HEIGHT ||
                                    cfg_idx == sgb_pkg::REG_KERNEL_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= 11'd500;
      height_r  <= 13'd500;
      ksize_r   <= 3'd3;
      coef_r[0] <= 16'd17961;
      coef_r[1] <= 16'd29614;
      coef_r[2] <= 16'd17961;
      coef_r[3] <= 16'd0;
      coef_r[4] <= 16'd0;
    end else if (cfg_acc) begin
      unique case (cfg_idx)
        sgb_pkg::REG_IMAGE_WIDTH:  width_r   <= cfg_ch.data[10:0];
        sgb_pkg::REG_IMAGE_HEIGHT: height_r  <= cfg_ch.data[12:0];
        sgb_pkg::REG_KERNEL_SIZE:  ksize_r   <= cfg_ch.data[2:0];
        sgb_pkg::REG_COEF_TAP0:    coef_r[0] <= cfg_ch.data;
        sgb_pkg::REG_COEF_TAP1:    coef_r[1] <= cfg_ch.data;
        sgb_pkg::REG_COEF_TAP2:    coef_r[2] <= cfg_ch.data;
        sgb_pkg::REG_COEF_TAP3:    coef_r[3] <= cfg_ch.data;
        sgb_pkg::REG_COEF_TAP4:    coef_r[4] <= cfg_ch.data;
      endcase
    end
  end

  // Effective geometry and radius.
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [CW-1:0] w_m1;
  logic [RW-1:0] h_m1;
  logic [1:0]    ks_half;
  logic [1:0]    r_val;
  logic [2:0]    two_r;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WW'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HW'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(height_r);
    end
    ks_half = (ksize_r == 3'd0) ? 2'd0 : 2'((ksize_r - 3'd1) >> 1);
    r_val   = (int'(ks_half) > RMAX) ? 2'(RMAX) : ks_half;
  end

  assign w_m1  = CW'(w_eff - WW'(1));
  assign h_m1  = RW'(h_eff - HW'(1));
  assign two_r = {r_val, 1'b0};

  // Weights per vertical tap and per window cell.
  sgb_pkg::coef_t vcoef [NT];
  sgb_pkg::coef_t hcoef [NT];

  always_comb begin
    for (int k = 0; k < NT; k++) begin
      vcoef[k] = '0;
      hcoef[k] = '0;
      if (k < sgb_pkg::NUM_COEF && k <= int'(two_r)) begin
        vcoef[k] = coef_r[k % sgb_pkg::NUM_COEF];
      end
      if (k <= int'(two_r)) begin
        hcoef[k] = coef_r[3'(int'(two_r) - k)];
      end
    end
  end

  // Pipeline enable: everything moves unless a held result is not taken.
  logic out_v_r;
  logic en;
  logic acc;

  assign en          = !out_v_r || out_ch.ready;
  assign in_ch.ready = en;
  assign acc         = in_ch.valid && en;

  // Position counters.
  logic [CW-1:0] ic_r, ic_nxt, vc_r, vc_nxt, oc_r, oc_nxt;
  logic [RW-1:0] ir_r, ir_nxt, vr_r, vr_nxt, or_r, or_nxt;
  logic [BW-1:0] ib_r, ib_nxt, vb_r, vb_nxt;
  logic [1:0]    warm_r, warm_nxt;
  logic          in_done_r, in_done_nxt, vdone_r, vdone_nxt;

  sgb_pkg::pix_t cur_pix;
  logic          act_in, produce, adv, vcall, emit, fend, vbord, hbord;
  logic          frame_restart;

  assign cur_pix = {in_ch.red_in, in_ch.green_in, in_ch.blue_in};
  assign act_in  = (sgb_pkg::op_t'(in_ch.operation) == sgb_pkg::OP_PIXEL) && !in_done_r;
  assign produce = act_in && (ir_r >= RW'(r_val));
  assign adv     = acc && (act_in ? produce : in_done_r);
  assign vcall   = act_in ? produce : !vdone_r;
  assign emit    = warm_r >= r_val;
  assign fend    = emit && (or_r == h_m1) && (oc_r == w_m1);
  assign vbord   = (vr_r < RW'(r_val)) ||
                   (({1'b0, vr_r} + (RW+1)'(r_val)) > {1'b0, h_m1});
  assign hbord   = (oc_r < CW'(r_val)) ||
                   (({1'b0, oc_r} + (CW+1)'(r_val)) > {1'b0, w_m1});

  always_comb begin
    ic_nxt      = ic_r;
    ir_nxt      = ir_r;
    ib_nxt      = ib_r;
    vc_nxt      = vc_r;
    vr_nxt      = vr_r;
    vb_nxt      = vb_r;
    oc_nxt      = oc_r;
    or_nxt      = or_r;
    warm_nxt    = warm_r;
    in_done_nxt = in_done_r;
    vdone_nxt   = vdone_r;
    frame_restart = cfg_restart;
    if (acc && act_in) begin
      if (ic_r == w_m1) begin
        ic_nxt = '0;
        if (ir_r == h_m1) begin
          ir_nxt      = '0;
          ib_nxt      = '0;
          in_done_nxt = 1'b1;
        end else begin
          ir_nxt = ir_r + RW'(1);
          ib_nxt = (ib_r == BW'(SR - 1)) ? '0 : ib_r + BW'(1);
        end
      end else begin
        ic_nxt = ic_r + CW'(1);
      end
    end
    if (adv && vcall) begin
      if (vc_r == w_m1) begin
        vc_nxt = '0;
        if (vr_r == h_m1) begin
          vdone_nxt = 1'b1;
        end else begin
          vr_nxt = vr_r + RW'(1);
          vb_nxt = (vb_r == BW'(SR - 1)) ? '0 : vb_r + BW'(1);
        end
      end else begin
        vc_nxt = vc_r + CW'(1);
      end
    end
    if (adv) begin
      if (!emit) begin
        warm_nxt = warm_r + 2'd1;
      end else if (fend) begin
        frame_restart = 1'b1;
      end else if (oc_r == w_m1) begin
        oc_nxt = '0;
        or_nxt = or_r + RW'(1);
      end else begin
        oc_nxt = oc_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || frame_restart) begin
      ic_r      <= '0;
      ir_r      <= '0;
      ib_r      <= '0;
      vc_r      <= '0;
      vr_r      <= '0;
      vb_r      <= '0;
      oc_r      <= '0;
      or_r      <= '0;
      warm_r    <= '0;
      in_done_r <= 1'b0;
      vdone_r   <= 1'b0;
    end else begin
      ic_r      <= ic_nxt;
      ir_r      <= ir_nxt;
      ib_r      <= ib_nxt;
      vc_r      <= vc_nxt;
      vr_r      <= vr_nxt;
      vb_r      <= vb_nxt;
      oc_r      <= oc_nxt;
      or_r      <= or_nxt;
      warm_r    <= warm_nxt;
      in_done_r <= in_done_nxt;
      vdone_r   <= vdone_nxt;
    end
  end

  // Source of each vertical tap: a stored row bank or the pixel arriving now.
  logic [BW-1:0] tbank [NT];
  logic          tcur  [NT];

  always_comb begin
    int t;
    for (int k = 0; k < NT; k++) begin
      t = int'(vb_r) + SR - int'(r_val) + k;
      if (t >= SR) t = t - SR;
      if (t >= SR) t = t - SR;
      tbank[k] = BW'(t);
      tcur[k]  = act_in && (k == int'(two_r));
    end
  end

  // Row store: one bank per stored row, all read at the same column.
  sgb_pkg::pix_t rd [SR];

  for (genvar j = 0; j < SR; j++) begin : g_bank
    sgb_ram #(.WIDTH(24), .DEPTH(MAX_WIDTH)) u_ram (
      .clk   (clk),
      .we    (acc && act_in && (ib_r == BW'(j))),
      .waddr (ic_r),
      .wdata (cur_pix),
      .re    (adv),
      .raddr (vc_r),
      .rdata (rd[j])
    );
  end

  // Stage 1: token beside the RAM read.
  logic          s1_v;
  logic          s1_vcall, s1_vbord, s1_ccur, s1_emit, s1_hbord, s1_end;
  logic [BW-1:0] s1_cbank;
  logic [BW-1:0] s1_tbank [NT];
  logic          s1_tcur  [NT];
  sgb_pkg::pix_t s1_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_vcall <= vcall;
      s1_vbord <= vbord;
      s1_ccur  <= act_in && (r_val == 2'd0);
      s1_cbank <= vb_r;
      s1_emit  <= emit;
      s1_hbord <= hbord;
      s1_end   <= fend;
      s1_cur   <= cur_pix;
      for (int k = 0; k < NT; k++) begin
        s1_tbank[k] <= tbank[k];
        s1_tcur[k]  <= tcur[k];
      end
    end
  end

  // Stage 2: vertical weighted terms.
  sgb_pkg::pix_t tpx [NT];
  sgb_pkg::pix_t cpx;

  always_comb begin
    for (int k = 0; k < NT; k++) begin
      tpx[k] = s1_tcur[k] ? s1_cur : rd[s1_tbank[k]];
    end
    cpx = s1_ccur ? s1_cur : rd[s1_cbank];
  end

  logic          s2_v;
  logic          s2_vcall, s2_vbord, s2_emit, s2_hbord, s2_end;
  sgb_pkg::pix_t s2_copy;
  sgb_pkg::pix_t s2_terms [NT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_vcall <= s1_vcall;
      s2_vbord <= s1_vbord;
      s2_emit  <= s1_emit;
      s2_hbord <= s1_hbord;
      s2_end   <= s1_end;
      s2_copy  <= cpx;
      for (int k = 0; k < NT; k++) begin
        s2_terms[k] <= sgb_pkg::pix_terms(tpx[k], vcoef[k]);
      end
    end
  end

  // Stage 3: vertical sum, saturation and border copy.
  sgb_pkg::pix_t vsat;
  sgb_pkg::pix_t vval;

  always_comb begin
    logic [SW-1:0] vsum;
    for (int ch = 0; ch < 3; ch++) begin
      vsum = '0;
      for (int k = 0; k < NT; k++) begin
        vsum = vsum + SW'(s2_terms[k][8*ch +: 8]);
      end
      vsat[8*ch +: 8] = (vsum > SW'(255)) ? 8'hFF : vsum[7:0];
    end
    if (!s2_vcall) begin
      vval = '0;
    end else if (s2_vbord) begin
      vval = s2_copy;
    end else begin
      vval = vsat;
    end
  end

  logic          s3_v;
  logic          s3_emit, s3_hbord, s3_end;
  sgb_pkg::pix_t s3_pix;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_emit  <= s2_emit;
      s3_hbord <= s2_hbord;
      s3_end   <= s2_end;
      s3_pix   <= vval;
    end
  end

  // Stage 4: the window cell chain. The last beat of a frame empties it.
  sgb_pkg::cell_ctrl_t cctl;
  sgb_pkg::pix_t       cin   [NT];
  sgb_pkg::pix_t       cq    [NT];
  sgb_pkg::pix_t       cprod [NT];

  assign cctl.shift = en && s3_v;
  assign cctl.clear = (en && s3_v && s3_end) || cfg_restart;
  assign cctl.load  = en;
  assign cin[0]     = s3_pix;

  for (genvar i = 0; i < NT; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign cin[i] = cq[i-1];
    end
    sgb_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (cctl),
      .pix_in (cin[i]),
      .coef   (hcoef[i]),
      .pix_q  (cq[i]),
      .prod_q (cprod[i])
    );
  end

  logic          s4_v;
  logic          s4_emit, s4_hbord, s4_end;
  sgb_pkg::pix_t s4_copy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_emit  <= s3_emit;
      s4_hbord <= s3_hbord;
      s4_end   <= s3_end;
      s4_copy  <= cin[r_val];
    end
  end

  // Stage 5: horizontal sum or border copy into the output register.
  sgb_pkg::pix_t hres;

  always_comb begin
    logic [SW-1:0] hsum;
    for (int ch = 0; ch < 3; ch++) begin
      hsum = '0;
      for (int k = 0; k < NT; k++) begin
        hsum = hsum + SW'(cprod[k][8*ch +: 8]);
      end
      hres[8*ch +: 8] = (hsum > SW'(255)) ? 8'hFF : hsum[7:0];
    end
    if (s4_hbord) begin
      hres = s4_copy;
    end
  end

  sgb_pkg::pix_t out_pix_r;
  logic          out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= s4_v && s4_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pix_r <= hres;
      out_end_r <= s4_end;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.blue_out  = out_pix_r[7:0];
  assign out_ch.green_out = out_pix_r[15:8];
  assign out_ch.red_out   = out_pix_r[23:16];
  assign out_ch.frame_end = out_end_r;

endmodule

// ===== sim/tb_checker.sv =====
// ----------------------------------------------------------------------------
// tb_checker
// Watches the register, pixel and result channels of the blur unit. It keeps
// its own copy of the line store and the row window and predicts each output
// beat, then compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module tb_checker
  import sgb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  sgb_cfg_if   cfg_ch,
  sgb_in_if    in_ch,
  sgb_out_if   out_ch,
  output int   fail_count,
  output int   pending,
  output int   checked
);

  localparam int LINE_W    = 1024;
  localparam int LINE_ROWS = 4;

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } blur_px_t;

  blur_px_t    blur_q[$];
  pix_t        line_mem [LINE_ROWS*LINE_W];
  pix_t        win [5];
  int unsigned in_col, in_row, out_col, out_row, v_col, v_row, warm;
  bit          in_done, v_done;
  int unsigned width_reg, height_reg, ksize_reg;
  coef_t       coefs [5];

  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w == 0) w = 1;
    if (w > LINE_W) w = LINE_W;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = height_reg;
    if (h == 0) h = 1;
    if (h > 4096) h = 4096;
    return h;
  endfunction

  function automatic int unsigned blur_radius();
    int unsigned r;
    r = (ksize_reg != 0) ? (ksize_reg - 1) / 2 : 0;
    if (r > 2) r = 2;
    return r;
  endfunction

  // Per channel: truncated Q0.16 products summed, then clipped to 255.
  function automatic pix_t weigh_taps(pix_t px [5], int unsigned r);
    pix_t        res;
    int unsigned sum;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      sum = 0;
      for (int k = 0; k <= 2*r; k++)
        sum += (int'(px[k][8*ch +: 8]) * int'(coefs[k])) >> 16;
      if (sum > 255) sum = 255;
      res[8*ch +: 8] = sum[7:0];
    end
    return res;
  endfunction

  function automatic pix_t line_read(int unsigned row, int unsigned col, bit has_cur,
                                     int unsigned cur_row, pix_t cur);
    if (has_cur && row == cur_row) return cur;
    return line_mem[(row % LINE_ROWS)*LINE_W + (col % LINE_W)];
  endfunction

  function automatic void frame_restart();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
    v_col = 0; v_row = 0; warm = 0;
    in_done = 0; v_done = 0;
    foreach (win[i]) win[i] = '0;
  endfunction

  function automatic pix_t column_pass(bit has_cur, int unsigned cur_row, pix_t cur);
    int unsigned r, h, w;
    pix_t        v;
    pix_t        taps [5];
    r = blur_radius(); h = eff_height(); w = eff_width();
    if (v_row < r || v_row + r >= h) begin
      v = line_read(v_row, v_col, has_cur, cur_row, cur);
    end else begin
      foreach (taps[k]) taps[k] = '0;
      for (int k = 0; k <= 2*r; k++)
        taps[k] = line_read(v_row - r + k, v_col, has_cur, cur_row, cur);
      v = weigh_taps(taps, r);
    end
    v_col++;
    if (v_col >= w) begin
      v_col = 0;
      v_row++;
      if (v_row >= h) v_done = 1;
    end
    return v;
  endfunction

  function automatic void row_pass(pix_t v);
    int unsigned r, h, w;
    pix_t        res;
    pix_t        taps [5];
    blur_px_t    e;
    r = blur_radius(); h = eff_height(); w = eff_width();
    for (int i = 4; i > 0; i--) win[i] = win[i-1];
    win[0] = v;
    if (warm < r) begin
      warm++;
      return;
    end
    if (out_col < r || out_col + r >= w) begin
      res = win[r];
    end else begin
      foreach (taps[k]) taps[k] = '0;
      for (int k = 0; k <= 2*r; k++) taps[k] = win[2*r - k];
      res = weigh_taps(taps, r);
    end
    e.blue  = res[7:0];
    e.green = res[15:8];
    e.red   = res[23:16];
    e.last  = (out_row + 1 >= h) && (out_col + 1 >= w);
    blur_q.push_back(e);
    if (e.last) begin
      frame_restart();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endfunction

  function automatic void take_pixel(op_t op, pix_t px);
    int unsigned r, ir;
    pix_t        v;
    if (op == OP_PIXEL && !in_done) begin
      r  = blur_radius();
      ir = in_row;
      v  = '0;
      if (ir >= r) v = column_pass(1, ir, px);
      line_mem[(ir % LINE_ROWS)*LINE_W + (in_col % LINE_W)] = px;
      in_col++;
      if (in_col >= eff_width()) begin
        in_col = 0;
        in_row++;
        if (in_row >= eff_height()) begin
          in_row  = 0;
          in_done = 1;
        end
      end
      if (ir >= r) row_pass(v);
    end else if (in_done) begin
      row_pass(v_done ? pix_t'('0) : column_pass(0, 0, '0));
    end
  endfunction

  function automatic void reg_write(cfg_reg_t idx, logic [15:0] d);
    case (idx)
      REG_IMAGE_WIDTH:  begin width_reg  = d[10:0]; frame_restart(); end
      REG_IMAGE_HEIGHT: begin height_reg = d[12:0]; frame_restart(); end
      REG_KERNEL_SIZE:  begin ksize_reg  = d[2:0];  frame_restart(); end
      REG_COEF_TAP0:    coefs[0] = d;
      REG_COEF_TAP1:    coefs[1] = d;
      REG_COEF_TAP2:    coefs[2] = d;
      REG_COEF_TAP3:    coefs[3] = d;
      REG_COEF_TAP4:    coefs[4] = d;
      default: ;
    endcase
  endfunction

  initial begin
    fail_count = 0;
    checked    = 0;
    width_reg  = 500;
    height_reg = 500;
    ksize_reg  = 3;
    coefs[0] = 17961; coefs[1] = 29614; coefs[2] = 17961; coefs[3] = 0; coefs[4] = 0;
    frame_restart();
  end

  assign pending = blur_q.size();

  always @(posedge clk) begin
    blur_px_t e;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (blur_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          e = blur_q.pop_front();
          checked++;
          if (out_ch.blue_out !== e.blue) begin
            $error("blue_out expected %0d got %0d", e.blue, out_ch.blue_out);
            fail_count++;
          end
          if (out_ch.green_out !== e.green) begin
            $error("green_out expected %0d got %0d", e.green, out_ch.green_out);
            fail_count++;
          end
          if (out_ch.red_out !== e.red) begin
            $error("red_out expected %0d got %0d", e.red, out_ch.red_out);
            fail_count++;
          end
          if (out_ch.frame_end !== e.last) begin
            $error("frame_end expected %0d got %0d", e.last, out_ch.frame_end);
            fail_count++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready)
        reg_write(cfg_reg_t'(cfg_ch.index), cfg_ch.data);
      if (in_ch.valid && in_ch.ready)
        take_pixel(op_t'(in_ch.operation), {in_ch.red_in, in_ch.green_in, in_ch.blue_in});
    end
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives frames of random and extreme pixels through the blur unit under a
// range of geometries, kernel sizes and weights, with drain ticks, aborted
// frames and random stalls on both sides; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_top;
  import sgb_pkg::*;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   checked;
  int   beats_sent;
  int   frames_run;
  bit   idle_on;
  bit   hold_req;
  bit   hold_used;

  sgb_cfg_if cfg_ch ();
  sgb_in_if  in_ch ();
  sgb_out_if out_ch ();

  separable_gaussian_blur_rgb_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_ch     (cfg_ch),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #20_000_000;
    $display("separable_gaussian_blur_rgb_unit verification failed");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_used) begin
        hold_used = 1;
        out_ch.ready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      out_ch.ready <= !(idle_on && $urandom_range(99) < 13);
    end
  end

  function automatic pix_t rand_pix();
    case ($urandom_range(5))
      0:       return 24'h000000;
      1:       return 24'hFFFFFF;
      default: return pix_t'($urandom);
    endcase
  endfunction

  task automatic send_beat(op_t op, pix_t px);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.blue_in   <= px[7:0];
    in_ch.green_in  <= px[15:8];
    in_ch.red_in    <= px[23:16];
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  task automatic reg_write(cfg_reg_t idx, logic [15:0] d);
    @(negedge clk);
    in_ch.valid  <= 1'b0;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Pixel results trail their input through the pipeline registers, so let those drain too.
  task automatic wait_idle();
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_weights(int a, int b, int c, int d, int e);
    reg_write(REG_COEF_TAP0, a[15:0]);
    reg_write(REG_COEF_TAP1, b[15:0]);
    reg_write(REG_COEF_TAP2, c[15:0]);
    reg_write(REG_COEF_TAP3, d[15:0]);
    reg_write(REG_COEF_TAP4, e[15:0]);
  endtask

  // One frame: data pixels with stray drain ticks, then the flush tail where
  // data beats are mixed in and must be treated as drain ticks. A cut-short
  // frame stops early and is abandoned by the next geometry write.
  task automatic run_frame(int w, int h, int ks, bit cut);
    int ew, eh, r, n_data, n_flush;
    ew = (w[10:0] == 0) ? 1 : (w[10:0] > 1024 ? 1024 : w[10:0]);
    eh = (h[12:0] == 0) ? 1 : (h[12:0] > 4096 ? 4096 : h[12:0]);
    r  = (ks == 0) ? 0 : (ks - 1) / 2;
    if (r > 2) r = 2;
    reg_write(REG_IMAGE_WIDTH, w[15:0]);
    reg_write(REG_IMAGE_HEIGHT, h[15:0]);
    reg_write(REG_KERNEL_SIZE, ks[15:0]);
    n_data = cut ? $urandom_range(ew*eh - 1) : ew*eh;
    for (int i = 0; i < n_data; i++) begin
      if ($urandom_range(99) < 5) send_beat(OP_DRAIN, rand_pix());
      send_beat(OP_PIXEL, rand_pix());
    end
    n_flush = cut ? $urandom_range(3) : r*ew + r;
    for (int i = 0; i < n_flush; i++)
      send_beat($urandom_range(3) == 0 ? OP_PIXEL : OP_DRAIN, rand_pix());
    repeat ($urandom_range(2)) send_beat(OP_DRAIN, rand_pix());
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait_idle();
    frames_run++;
  endtask

  initial begin
    int ks_pick [8] = '{1, 3, 3, 5, 5, 5, 0, 4};
    rst_n            = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = REG_IMAGE_WIDTH;
    cfg_ch.data      = '0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_PIXEL;
    in_ch.blue_in    = '0;
    in_ch.green_in   = '0;
    in_ch.red_in     = '0;
    beats_sent       = 0;
    frames_run       = 0;
    idle_on          = 1;
    hold_req         = 0;
    hold_used        = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset weights, saturation, zero weights, every kernel size,
    // degenerate width and height, images no larger than the kernel.
    run_frame(5, 5, 3, 0);
    set_weights(65535, 65535, 65535, 65535, 65535);
    run_frame(6, 6, 5, 0);
    set_weights(0, 0, 0, 0, 0);
    run_frame(5, 5, 5, 0);
    set_weights(16384, 32768, 16384, 8192, 4096);
    run_frame(3, 2, 1, 0);
    run_frame(4, 3, 0, 0);
    run_frame(4, 4, 2, 0);
    run_frame(6, 5, 4, 0);
    run_frame(7, 6, 6, 0);
    run_frame(6, 7, 7, 0);
    run_frame(0, 0, 5, 0);
    run_frame(4, 3, 5, 0);

    // A full-width row sent with no idling on either side.
    idle_on = 0;
    run_frame(2047, 1, 1, 0);
    idle_on = 1;

    // Random frames, mostly small. The first has the result side stall long
    // enough to back the block up.
    while (beats_sent < 1650) begin
      if (!hold_used) hold_req = 1;
      if ($urandom_range(2) == 0)
        set_weights($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                    $urandom_range(3) == 0 ? 65535 : $urandom_range(20000),
                    $urandom_range(3) == 0 ? 0 : $urandom_range(20000));
      run_frame($urandom_range(9) == 0 ? $urandom_range(40, 1) : $urandom_range(12, 1),
                $urandom_range(10, 1), ks_pick[$urandom_range(7)],
                $urandom_range(9) == 0);
    end
    idle_on = 1;
    repeat (40) @(posedge clk);

    $display("Ran %0d frames of %0d input beats, %0d filtered pixels compared.",
             frames_run, beats_sent, checked);
    if (fail_count == 0) begin
      $display("separable_gaussian_blur_rgb_unit verification clean");
    end else begin
      $display("separable_gaussian_blur_rgb_unit verification failed");
    end
    $finish;
  end

endmodule
